FILE: rtl/bhl_pkg.sv
package bhl_pkg;

	// Configuration port widths and register indexes.
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 11;

	localparam logic [CFG_IW-1:0] CFG_SOURCE = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_COUNT  = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_LIMIT  = 2'd2;

	// Controller states.
	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_LDA_RD,
		S_LDA_WR,
		S_LDB_RD,
		S_LDB_WR,
		S_SRC,
		S_POP,
		S_HEAD,
		S_FIRST,
		S_LINK,
		S_ADJ,
		S_VISIT,
		S_SCAN,
		S_SC_EDGE,
		S_SC_DIST,
		S_SC_CMP,
		S_DONE
	} bhl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic wr_link_a;
		logic wr_link_b;
		logic srch_init;
		logic pop;
		logic rd_head_u;
		logic rd_head_b;
		logic take_head;
		logic take_adj;
		logic visit;
		logic scan_init;
		logic rd_dist;
		logic scan_upd;
		logic clr_init;
		logic clr_step;
	} bhl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic load_ok;
		logic item_last;
		logic last_q;
		logic src_ok;
		logic q_empty;
		logic link_zero;
		logic scan_done;
		logic clr_last;
	} bhl_status_t;

endpackage

FILE: rtl/bfs_hop_limited_edge_max_unit.sv
// Hop-limited edge maximum over a breadth-first search.
// Input beats are taken at a rising edge with start high and busy low. A beat
// with edge_valid high, both endpoints in 1..MAX_NODES and a free edge slot
// stores one undirected edge; a beat with last_item high closes the batch,
// runs the search from the configured source node and reports the largest
// qualifying weight (floored at zero) on max_weight with done high for
// exactly one cycle. The receiver cannot stall; the result must be taken
// then. An edge beat holds busy while the adjacency head of each endpoint is
// read and rewritten in turn. After the last beat, the search pops each
// reached node, reads its head and follows its links through the link and
// queue memories; the scan reads each stored edge and its endpoint distances
// and compares its weight; done follows. After each result and after reset,
// a clearing pass empties the adjacency heads and reached flags; busy stays
// high throughout. Configuration is written through cfg_we, cfg_index and
// cfg_data by the user only while idle; the block does not enforce it.
module bfs_hop_limited_edge_max_unit #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_EDGES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bhl_pkg::CFG_IW-1:0] cfg_index,
	input  logic [bhl_pkg::CFG_DW-1:0] cfg_data,
	input  logic                       start,
	output logic                       busy,
	input  logic                       edge_valid,
	input  logic [10:0]                end_a,
	input  logic [10:0]                end_b,
	input  logic signed [31:0]         edge_weight,
	input  logic                       last_item,
	output logic                       done,
	output logic [30:0]                max_weight
);
	import bhl_pkg::*;

	bhl_cmd_t    cmd;
	bhl_status_t status;

	bhl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bhl_dp #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.edge_valid  (edge_valid),
		.end_a       (end_a),
		.end_b       (end_b),
		.edge_weight (edge_weight),
		.last_item   (last_item),
		.max_weight  (max_weight)
	);

`ifndef SYNTHESIS
	// A result never coincides with an accepted beat.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while not busy");

	// A result is followed by the clearing pass, never by a second result.
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (busy && !done)) else $error("no clearing pass after result");

	// A closing beat keeps the block busy for the search.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_item) |=> busy) else $error("search not started");
`endif

endmodule

FILE: rtl/bhl_ctrl.sv
module bhl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  bhl_pkg::bhl_status_t status,
	output bhl_pkg::bhl_cmd_t    cmd,
	output logic                 busy,
	output logic                 done
);
	import bhl_pkg::*;

	bhl_state_t state_q, state_d;

	// State register; reset starts with the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (status.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (status.load_ok) state_d = S_LDA_RD;
					else if (status.item_last) state_d = S_SRC;
				end
			end
			S_LDA_RD: state_d = S_LDA_WR;
			S_LDA_WR: state_d = S_LDB_RD;
			S_LDB_RD: state_d = S_LDB_WR;
			S_LDB_WR: state_d = status.last_q ? S_SRC : S_IDLE;
			S_SRC:    state_d = status.src_ok ? S_POP : S_SCAN;
			S_POP:    state_d = status.q_empty ? S_SCAN : S_HEAD;
			S_HEAD:   state_d = S_FIRST;
			S_FIRST:  state_d = S_LINK;
			S_LINK:   state_d = status.link_zero ? S_POP : S_ADJ;
			S_ADJ:    state_d = S_VISIT;
			S_VISIT:  state_d = S_LINK;
			S_SCAN:   state_d = S_SC_EDGE;
			S_SC_EDGE: state_d = status.scan_done ? S_DONE : S_SC_DIST;
			S_SC_DIST: state_d = S_SC_CMP;
			S_SC_CMP:  state_d = S_SC_EDGE;
			S_DONE:    state_d = S_CLEAR;
			default:   state_d = S_CLEAR;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				busy = 1'b0;
				cmd.capture = start;
			end
			S_LDA_WR:  cmd.wr_link_a = 1'b1;
			S_LDB_RD:  cmd.rd_head_b = 1'b1;
			S_LDB_WR:  cmd.wr_link_b = 1'b1;
			S_SRC:     cmd.srch_init = 1'b1;
			S_POP:     cmd.pop = !status.q_empty;
			S_HEAD:    cmd.rd_head_u = 1'b1;
			S_FIRST:   cmd.take_head = 1'b1;
			S_ADJ:     cmd.take_adj = 1'b1;
			S_VISIT:   cmd.visit = 1'b1;
			S_SCAN:    cmd.scan_init = 1'b1;
			S_SC_DIST: cmd.rd_dist = 1'b1;
			S_SC_CMP:  cmd.scan_upd = 1'b1;
			S_DONE: begin
				done = 1'b1;
				cmd.clr_init = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/bhl_dp.sv
module bhl_dp #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_EDGES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bhl_pkg::bhl_cmd_t             cmd,
	output bhl_pkg::bhl_status_t          status,
	input  logic                          cfg_we,
	input  logic [bhl_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [bhl_pkg::CFG_DW-1:0]    cfg_data,
	input  logic                          edge_valid,
	input  logic [10:0]                   end_a,
	input  logic [10:0]                   end_b,
	input  logic signed [31:0]            edge_weight,
	input  logic                          last_item,
	output logic [30:0]                   max_weight
);
	import bhl_pkg::*;

	localparam int NW  = $clog2(MAX_NODES + 1);
	localparam int DW  = $clog2(MAX_NODES);
	localparam int CW  = (NW > 11) ? NW : 11;
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ETW = $clog2(MAX_EDGES + 1);
	localparam int SW  = $clog2(2 * MAX_EDGES);
	localparam int LW  = $clog2(2 * MAX_EDGES + 1);
	localparam int QAW = $clog2(MAX_NODES);
	localparam int QCW = $clog2(MAX_NODES + 1);

	// Configuration registers.
	logic [CFG_DW-1:0] src_q, cnt_cfg_q, lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q     <= CFG_DW'(1);
			cnt_cfg_q <= CFG_DW'(1);
			lim_q     <= CFG_DW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOURCE: src_q     <= cfg_data;
				CFG_COUNT:  cnt_cfg_q <= cfg_data;
				CFG_LIMIT:  lim_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Node count saturated to the capacity.
	logic [CW-1:0] cnt_ext, cnt_sat;
	assign cnt_ext = CW'(cnt_cfg_q);
	assign cnt_sat = (cnt_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : cnt_ext;

	// Captured input beat.
	logic [NW-1:0] a_q, b_q;
	logic [31:0]   w_q;
	logic          last_q;
	logic [ETW-1:0] total_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			a_q    <= NW'(end_a);
			b_q    <= NW'(end_b);
			w_q    <= edge_weight;
			last_q <= last_item;
		end
	end

	// Memories and their registered read data.
	logic [LW-1:0]        head_mem [0:MAX_NODES];
	logic [NW+LW-1:0]     adj_mem  [0:2*MAX_EDGES-1];
	logic [2*NW+31:0]     edge_mem [0:MAX_EDGES-1];
	logic [DW:0]          dist_mem [0:MAX_NODES];
	logic [NW+DW-1:0]     queue_mem [0:MAX_NODES-1];

	logic [LW-1:0]    head_rd_q;
	logic [NW+LW-1:0] adj_rd_q;
	logic [2*NW+31:0] edge_rd_q;
	logic [DW:0]      dist_a_q, dist_b_q;
	logic [NW+DW-1:0] queue_rd_q;

	// Search and scan registers.
	logic [QCW-1:0] rd_q, wr_q;
	logic [DW-1:0]  du_q;
	logic [LW-1:0]  link_q;
	logic [NW-1:0]  v_q;
	logic [ETW-1:0] idx_q;
	logic [30:0]    best_q;
	logic [NW-1:0]  clr_q;

	// Field views of the read data.
	logic [NW-1:0] q_node, adj_tgt, e_a, e_b;
	logic [LW-1:0] adj_next;
	logic [31:0]   e_w;
	assign q_node   = queue_rd_q[NW+DW-1:DW];
	assign adj_tgt  = adj_rd_q[NW+LW-1:LW];
	assign adj_next = adj_rd_q[LW-1:0];
	assign e_a      = edge_rd_q[2*NW+31:NW+32];
	assign e_b      = edge_rd_q[NW+31:32];
	assign e_w      = edge_rd_q[31:0];

	// Slot of the link being written during a load.
	logic [SW-1:0] slot_w;
	logic [LW-1:0] link_w;
	assign slot_w = (SW'(total_q) << 1) | SW'(cmd.wr_link_b);
	assign link_w = LW'(slot_w) + LW'(1);

	// Search decisions.
	logic src_ok, visit_ok, qa, qb;
	logic [DW-1:0] dv;
	assign src_ok   = (src_q != '0) && (CW'(src_q) <= cnt_sat);
	assign visit_ok = (CW'(v_q) <= cnt_sat) && !dist_a_q[DW];
	assign dv       = du_q + DW'(1);
	assign qa = !dist_a_q[DW] || (CW'(dist_a_q[DW-1:0]) < CW'(lim_q));
	assign qb = !dist_b_q[DW] || (CW'(dist_b_q[DW-1:0]) < CW'(lim_q));

	// Adjacency head memory; the head of the second endpoint is read after
	// the first endpoint's head has been updated.
	logic          head_we;
	logic [NW-1:0] head_wa, head_ra;
	logic [LW-1:0] head_wd;
	assign head_we = cmd.wr_link_a || cmd.wr_link_b || cmd.clr_step;
	assign head_wa = cmd.clr_step ? clr_q : (cmd.wr_link_b ? b_q : a_q);
	assign head_wd = cmd.clr_step ? '0 : link_w;
	assign head_ra = cmd.rd_head_u ? q_node : (cmd.rd_head_b ? b_q : a_q);

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[head_ra];
	end

	// Link memory: target node and next link per slot.
	always_ff @(posedge clk) begin
		if (cmd.wr_link_a || cmd.wr_link_b)
			adj_mem[slot_w] <= {(cmd.wr_link_b ? a_q : b_q), head_rd_q};
		adj_rd_q <= adj_mem[SW'(link_q - LW'(1))];
	end

	// Edge store.
	always_ff @(posedge clk) begin
		if (cmd.wr_link_a) edge_mem[EAW'(total_q)] <= {a_q, b_q, w_q};
		edge_rd_q <= edge_mem[EAW'(idx_q)];
	end

	// Distance memory: reached flag and hop count, two read ports.
	logic          dist_we;
	logic [NW-1:0] dist_wa;
	logic [DW:0]   dist_wd;
	assign dist_we = (cmd.srch_init && src_ok) || (cmd.visit && visit_ok) || cmd.clr_step;
	assign dist_wa = cmd.clr_step ? clr_q : (cmd.srch_init ? NW'(src_q) : v_q);
	assign dist_wd = cmd.clr_step ? '0 : (cmd.srch_init ? {1'b1, DW'(0)} : {1'b1, dv});

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_wa] <= dist_wd;
		dist_a_q <= dist_mem[cmd.rd_dist ? e_a : adj_tgt];
		dist_b_q <= dist_mem[e_b];
	end

	// Search queue of node and hop count.
	logic            queue_we;
	logic [QAW-1:0]  queue_wa;
	logic [NW+DW-1:0] queue_wd;
	assign queue_we = (cmd.srch_init && src_ok) || (cmd.visit && visit_ok);
	assign queue_wa = cmd.srch_init ? QAW'(0) : QAW'(wr_q);
	assign queue_wd = cmd.srch_init ? {NW'(src_q), DW'(0)} : {v_q, dv};

	always_ff @(posedge clk) begin
		if (queue_we) queue_mem[queue_wa] <= queue_wd;
		queue_rd_q <= queue_mem[QAW'(rd_q)];
	end

	// Counters and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			clr_q   <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.wr_link_b) total_q <= total_q + ETW'(1);
			if (cmd.clr_init) begin
				total_q <= '0;
				clr_q   <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + NW'(1);
			end
			if (cmd.srch_init) begin
				rd_q <= '0;
				wr_q <= src_ok ? QCW'(1) : '0;
			end
			if (cmd.pop) rd_q <= rd_q + QCW'(1);
			if (cmd.visit && visit_ok) wr_q <= wr_q + QCW'(1);
			if (cmd.scan_init) idx_q <= '0;
			else if (cmd.scan_upd) idx_q <= idx_q + ETW'(1);
		end
	end

	// Traversal and result registers.
	always_ff @(posedge clk) begin
		if (cmd.rd_head_u) du_q <= queue_rd_q[DW-1:0];
		if (cmd.take_head) link_q <= head_rd_q;
		if (cmd.take_adj) begin
			link_q <= adj_next;
			v_q    <= adj_tgt;
		end
		if (cmd.scan_init) best_q <= '0;
		else if (cmd.scan_upd && (qa || qb) && !e_w[31] && (e_w[30:0] > best_q))
			best_q <= e_w[30:0];
	end

	assign max_weight = best_q;

	// Status back to the controller.
	always_comb begin
		status.load_ok   = edge_valid
			&& (end_a != '0) && (CW'(end_a) <= CW'(MAX_NODES))
			&& (end_b != '0) && (CW'(end_b) <= CW'(MAX_NODES))
			&& (total_q != ETW'(MAX_EDGES));
		status.item_last = last_item;
		status.last_q    = last_q;
		status.src_ok    = src_ok;
		status.q_empty   = (rd_q == wr_q);
		status.link_zero = (link_q == '0);
		status.scan_done = (idx_q == total_q);
		status.clr_last  = (clr_q == NW'(MAX_NODES));
	end

endmodule
